// ----- rtl/at2_pkg.sv -----
// Shared constants, widths and types for the atan2 rational approximation block.
package at2_pkg;

  // Coordinate width; the magnitude and remainder widths below follow from it (range 8..32).
  localparam int COORD_BITS = 16;

  // Magnitudes and denominators reach 2^COORD_BITS.
  localparam int MAG_W = COORD_BITS + 1;
  // Partial remainder of the divider: one bit of headroom for the shift.
  localparam int REM_W = COORD_BITS + 2;

  // Ratio r is signed Q1.15.
  localparam int R_FRAC = 15;
  localparam int R_W    = R_FRAC + 1;
  // Raw quotient floor(a * 2^(R_FRAC+1) / d), a <= d, so it needs R_FRAC + 2 bits.
  localparam int QUO_W  = R_FRAC + 2;

  // Polynomial products.
  localparam int R2_W  = 2 * R_W;
  localparam int R3_W  = 3 * R_W;
  localparam int LIN_W = 2 * R_W;
  localparam int P3_W  = R3_W + 14;
  localparam int SUM_W = P3_W + 1;
  // Sum is at 3*R_FRAC + 15 = 60 fraction bits; the angle keeps 13.
  localparam int SUM_FRAC = 4 * R_FRAC;
  localparam int ANG_FRAC = 13;
  localparam int RND_SH   = SUM_FRAC - ANG_FRAC;
  localparam int LIN_SH   = SUM_FRAC - 2 * R_FRAC;

  // Angle is signed Q3.13; the wide form has room for offset and negation.
  localparam int ANG_W  = 16;
  localparam int ANGX_W = ANG_W + 2;

  localparam logic signed [R_W-1:0] R_MAX  = 16'sd32767;
  localparam logic signed [R_W-1:0] C_CUBE = 16'sd6432;   // 0.1963 in Q1.15
  localparam logic signed [R_W-1:0] C_LIN  = 16'sd32169;  // 0.9817 in Q1.15

  localparam logic signed [ANG_W-1:0] Q_PI_4  = 16'sd6434;
  localparam logic signed [ANG_W-1:0] Q_PI_2  = 16'sd12868;
  localparam logic signed [ANG_W-1:0] Q_3PI_4 = 16'sd19302;
  localparam logic signed [ANG_W-1:0] Q_PI    = 16'sd25736;

  // Flags that ride along with each transaction down the pipeline.
  typedef struct packed {
    logic valid;
    logic xzero;  // x == 0: angle is +-pi/2, ratio path ignored
    logic ypos;   // y > 0
    logic yneg;   // y < 0: negate the angle
    logic xneg;   // x < 0: offset 3pi/4 instead of pi/4
  } at2_tag_t;

endpackage

// ----- rtl/at2_div.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
module at2_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  at2_pkg::at2_tag_t            in_tag,
  input  logic [at2_pkg::MAG_W-1:0]    in_mag,
  input  logic [at2_pkg::MAG_W-1:0]    in_den,
  input  logic                         in_nneg,
  output at2_pkg::at2_tag_t            out_tag,
  output logic [at2_pkg::QUO_W-1:0]    out_quo,
  output logic                         out_nneg
);
  import at2_pkg::*;

  at2_tag_t          tag_r  [QUO_W];
  logic [REM_W-1:0]  rem_r  [QUO_W];
  logic [QUO_W-1:0]  quo_r  [QUO_W];
  logic [MAG_W-1:0]  den_r  [QUO_W];
  logic              nneg_r [QUO_W];

  // Stage inputs: stage 0 from the ports, stage i from stage i-1.
  at2_tag_t          src_tag  [QUO_W];
  logic [REM_W-1:0]  src_part [QUO_W];
  logic [QUO_W-1:0]  src_quo  [QUO_W];
  logic [MAG_W-1:0]  src_den  [QUO_W];
  logic              src_nneg [QUO_W];

  logic              ge       [QUO_W];
  logic [REM_W-1:0]  rem_nxt  [QUO_W];
  logic [QUO_W-1:0]  quo_nxt  [QUO_W];

  always_comb begin
    src_tag[0]  = in_tag;
    src_part[0] = REM_W'(in_mag);   // a <= d, so the top quotient bit is a >= d
    src_quo[0]  = '0;
    src_den[0]  = in_den;
    src_nneg[0] = in_nneg;
    for (int i = 1; i < QUO_W; i++) begin
      src_tag[i]  = tag_r[i-1];
      src_part[i] = {rem_r[i-1][REM_W-2:0], 1'b0};
      src_quo[i]  = quo_r[i-1];
      src_den[i]  = den_r[i-1];
      src_nneg[i] = nneg_r[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < QUO_W; i++) begin
      ge[i]      = src_part[i] >= REM_W'(src_den[i]);
      rem_nxt[i] = ge[i] ? (src_part[i] - REM_W'(src_den[i])) : src_part[i];
      quo_nxt[i] = {src_quo[i][QUO_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) tag_r[i] <= '0;
    end else begin
      for (int i = 0; i < QUO_W; i++) tag_r[i] <= src_tag[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUO_W; i++) begin
      rem_r[i]  <= rem_nxt[i];
      quo_r[i]  <= quo_nxt[i];
      den_r[i]  <= src_den[i];
      nneg_r[i] <= src_nneg[i];
    end
  end

  assign out_tag  = tag_r[QUO_W-1];
  assign out_quo  = quo_r[QUO_W-1];
  assign out_nneg = nneg_r[QUO_W-1];

endmodule

// ----- rtl/atan2_rational_approx.sv -----
// Top level: pipelined atan2 approximation, ratio divider plus cubic polynomial.
// Throughput: one transaction per cycle; busy is low except during reset and the cycle after it.
// The 17-stage bit-per-stage divider sets the depth; three multiplier stages follow.
// Reset (rst_n low, synchronous) clears all valid bits; no output is pending after it.
// The receiver cannot stall: each result shows for exactly one cycle on out_valid.
module atan2_rational_approx (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [at2_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic signed [at2_pkg::COORD_BITS-1:0] in_coord_x,
  output logic                                  out_valid,
  output logic signed [at2_pkg::ANG_W-1:0]      out_angle
);
  import at2_pkg::*;

  // accept edge -> edge at which the result is taken
  localparam int LATENCY = QUO_W + 7;

  logic accepted;
  logic busy_r;

  // Apart from reset itself, only the cycle right after reset refuses a transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy     = busy_r;
  assign accepted = start && !busy_r;

  // ---------------------------------------------------------------
  // Stage 0: fold the quadrant into numerator / denominator.
  //   x >= 0: num = x - |y|, den = x + |y|
  //   x <  0: num = x + |y|, den = |y| - x
  // |num| <= den always, so r stays within [-1, 1].
  // ---------------------------------------------------------------
  logic signed [REM_W-1:0] x_s, y_s, ay_s, num_s, den_s;
  logic                    xneg;
  at2_tag_t                s0_tag_nxt, s0_tag_r;
  logic [MAG_W-1:0]        s0_mag_nxt, s0_mag_r;
  logic [MAG_W-1:0]        s0_den_nxt, s0_den_r;
  logic                    s0_nneg_nxt, s0_nneg_r;

  always_comb begin
    x_s   = {{(REM_W-COORD_BITS){in_coord_x[COORD_BITS-1]}}, in_coord_x};
    y_s   = {{(REM_W-COORD_BITS){in_coord_y[COORD_BITS-1]}}, in_coord_y};
    ay_s  = y_s[REM_W-1] ? -y_s : y_s;
    xneg  = x_s[REM_W-1];
    num_s = xneg ? (x_s + ay_s) : (x_s - ay_s);
    den_s = xneg ? (ay_s - x_s) : (x_s + ay_s);

    s0_tag_nxt.valid = accepted;
    s0_tag_nxt.xzero = (in_coord_x == '0);
    s0_tag_nxt.ypos  = !in_coord_y[COORD_BITS-1] && (in_coord_y != '0);
    s0_tag_nxt.yneg  = in_coord_y[COORD_BITS-1];
    s0_tag_nxt.xneg  = xneg;

    s0_nneg_nxt = num_s[REM_W-1];
    s0_mag_nxt  = s0_nneg_nxt ? MAG_W'(-num_s) : MAG_W'(num_s);
    s0_den_nxt  = MAG_W'(den_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_tag_r <= '0;
    end else begin
      s0_tag_r <= s0_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_mag_r  <= s0_mag_nxt;
    s0_den_r  <= s0_den_nxt;
    s0_nneg_r <= s0_nneg_nxt;
  end

  // ---------------------------------------------------------------
  // Divider: quo = floor(|num| * 2^16 / den), one bit per stage.
  // den is zero only at the origin, where the x == 0 path wins.
  // ---------------------------------------------------------------
  at2_tag_t         dv_tag;
  logic [QUO_W-1:0] dv_quo;
  logic             dv_nneg;

  at2_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (s0_tag_r),
    .in_mag   (s0_mag_r),
    .in_den   (s0_den_r),
    .in_nneg  (s0_nneg_r),
    .out_tag  (dv_tag),
    .out_quo  (dv_quo),
    .out_nneg (dv_nneg)
  );

  // ---------------------------------------------------------------
  // Round stage: q = (quo + 1) >> 1 is |num|/den in Q1.15, rounded
  // half away from zero. +1 saturates to R_MAX; -1 fits as is.
  // ---------------------------------------------------------------
  logic [QUO_W-1:0]        q_half;
  logic signed [R_W-1:0]   r_nxt, r_r;
  at2_tag_t                rd_tag_r;

  always_comb begin
    q_half = QUO_W'(({1'b0, dv_quo} + (QUO_W+1)'(1)) >> 1);
    if (dv_nneg) begin
      r_nxt = R_W'(~q_half + QUO_W'(1));
    end else if (q_half > QUO_W'(R_MAX)) begin
      r_nxt = R_MAX;
    end else begin
      r_nxt = R_W'(q_half);
    end
  end

  // ---------------------------------------------------------------
  // Multiplier stages, one product per register:
  //   m1: r^2 and C_LIN * r
  //   m2: r^3
  //   m3: C_CUBE * r^3
  // ---------------------------------------------------------------
  logic signed [R_W-1:0]   m1_r_r;
  logic signed [R2_W-1:0]  m1_r2_r;
  logic signed [LIN_W-1:0] m1_lin_r, m2_lin_r, m3_lin_r;
  logic signed [R3_W-1:0]  m2_r3_r;
  logic signed [P3_W-1:0]  m3_p3_r;
  at2_tag_t                m1_tag_r, m2_tag_r, m3_tag_r;

  // Sum stage: exact at 60 fraction bits, then round half up to Q3.13.
  logic signed [SUM_W-1:0] sum_s;
  logic signed [ANG_W-1:0] rnd_nxt, rnd_r;
  at2_tag_t                sm_tag_r;

  always_comb begin
    sum_s = {{(SUM_W-P3_W){m3_p3_r[P3_W-1]}}, m3_p3_r}
          - ({{(SUM_W-LIN_W){m3_lin_r[LIN_W-1]}}, m3_lin_r} <<< LIN_SH)
          + (SUM_W'(1) <<< (RND_SH - 1));
    rnd_nxt = sum_s[RND_SH +: ANG_W];
  end

  // Final stage: add the quadrant offset, mirror for negative y, clamp; x == 0 gives +-pi/2.
  logic signed [ANGX_W-1:0] base_s, sgn_s;
  logic signed [ANG_W-1:0]  ang_nxt, out_angle_r;
  logic                     out_valid_r;

  always_comb begin
    base_s = ANGX_W'(rnd_r)
           + ANGX_W'(sm_tag_r.xneg ? Q_3PI_4 : Q_PI_4);
    sgn_s  = sm_tag_r.yneg ? -base_s : base_s;
    if (sm_tag_r.xzero) begin
      ang_nxt = sm_tag_r.ypos ? Q_PI_2 : -Q_PI_2;
    end else if (sgn_s > ANGX_W'(Q_PI)) begin
      ang_nxt = Q_PI;
    end else if (sgn_s < -ANGX_W'(Q_PI)) begin
      ang_nxt = -Q_PI;
    end else begin
      ang_nxt = ANG_W'(sgn_s);
    end
  end

  // valid bits and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r    <= '0;
      m1_tag_r    <= '0;
      m2_tag_r    <= '0;
      m3_tag_r    <= '0;
      sm_tag_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_tag_r    <= dv_tag;
      m1_tag_r    <= rd_tag_r;
      m2_tag_r    <= m1_tag_r;
      m3_tag_r    <= m2_tag_r;
      sm_tag_r    <= m3_tag_r;
      out_valid_r <= sm_tag_r.valid;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    r_r         <= r_nxt;
    m1_r_r      <= r_r;
    m1_r2_r     <= r_r * r_r;
    m1_lin_r    <= r_r * C_LIN;
    m2_r3_r     <= m1_r2_r * m1_r_r;
    m2_lin_r    <= m1_lin_r;
    m3_p3_r     <= m2_r3_r * C_CUBE;
    m3_lin_r    <= m2_lin_r;
    rnd_r       <= rnd_nxt;
    out_angle_r <= ang_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accepted |-> ##LATENCY out_valid)
    else $error("accepted transaction produced no result at the expected cycle");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accepted, LATENCY))
    else $error("result strobe without a matching accepted transaction");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle <= Q_PI) && (out_angle >= -Q_PI))
    else $error("angle outside -pi..pi");

  a_axis_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (accepted && in_coord_x == '0 && !in_coord_y[COORD_BITS-1] && in_coord_y != '0)
      |-> ##LATENCY (out_angle == Q_PI_2))
    else $error("positive y axis did not give +pi/2");

  a_axis_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (accepted && in_coord_x == '0 && (in_coord_y[COORD_BITS-1] || in_coord_y == '0))
      |-> ##LATENCY (out_angle == -Q_PI_2))
    else $error("negative y axis or origin did not give -pi/2");

endmodule

// ----- tb/atan2_rational_approx_tb.sv -----
// Self-checking testbench for the atan2 rational approximation block.
`timescale 1ns / 100ps

module atan2_rational_approx_tb;
  import at2_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ANG_W-1:0]      angle_t;

  localparam coord_t C_MAX = coord_t'((longint'(1) << (COORD_BITS - 1)) - 1);
  localparam coord_t C_MIN = coord_t'(-(longint'(1) << (COORD_BITS - 1)));

  // Cycles with no transaction on either side before the run is declared hung.
  // The limit exceeds the pipeline depth, and sender gaps are capped at MAX_GAP.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_GAP        = 60;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 470;

  // Scoreboard: predicts the angle of each accepted coordinate pair and
  // checks results in order (one result per transaction, no reordering).
  class angle_scoreboard;
    angle_t expected_angles[$];
    coord_t pending_coords[$][2];
    int     errors;
    int     pairs_seen;
    int     angles_checked;
    int     axis_pairs;
    int     right_pairs;
    int     left_pairs;

    // Fixed-point angle of (x, y): Q1.15 ratio, cubic in r summed at 60
    // fraction bits, rounded to Q3.13, offset by pi/4 or 3pi/4, signed by y.
    function angle_t predict_angle(coord_t y, coord_t x);
      longint yy, xx, ay, num, den, mag, quo, r, r3, acc, ang, offs;
      yy = y;
      xx = x;
      ay = (yy < 0) ? -yy : yy;
      if (xx == 0) begin
        // y axis, origin included: only y > 0 gives +pi/2
        ang = (yy > 0) ? longint'(Q_PI_2) : -longint'(Q_PI_2);
      end else begin
        if (xx > 0) begin
          num  = xx - ay;
          den  = xx + ay;
          offs = Q_PI_4;
        end else begin
          num  = xx + ay;
          den  = ay - xx;
          offs = Q_3PI_4;
        end
        // quotient rounded to nearest, halves away from zero
        mag = (num < 0) ? -num : num;
        quo = (mag * 65536 + den) / (2 * den);
        r   = (num < 0) ? -quo : quo;
        // r = +1 (positive x axis) does not fit Q1.15
        if (r > longint'(R_MAX)) r = R_MAX;
        if (r < -32768) r = -32768;
        r3  = r * r * r;
        acc = longint'(C_CUBE) * r3 - (longint'(C_LIN) * r) * (longint'(1) << 30);
        // round half up to 13 fraction bits; arithmetic shift is a floor
        ang = ((acc + (longint'(1) << 46)) >>> 47) + offs;
        if (yy < 0) ang = -ang;
      end
      if (ang > longint'(Q_PI)) ang = Q_PI;
      if (ang < -longint'(Q_PI)) ang = -longint'(Q_PI);
      return angle_t'(ang);
    endfunction

    function void note_pair(coord_t y, coord_t x);
      coord_t yx[2];
      yx = '{y, x};
      expected_angles.push_back(predict_angle(y, x));
      pending_coords.push_back(yx);
      pairs_seen++;
      if (x == 0) axis_pairs++;
      else if (x > 0) right_pairs++;
      else left_pairs++;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_angle(angle_t got);
      angle_t want;
      coord_t yx[2];
      if (expected_angles.size() == 0) begin
        report($sformatf("result %0d with no transaction outstanding", got));
      end else begin
        want = expected_angles.pop_front();
        yx   = pending_coords.pop_front();
        angles_checked++;
        if (got !== want)
          report($sformatf("y=%0d x=%0d: angle %0d, expected %0d", yx[0], yx[1], got, want));
      end
    endtask

    function int pending();
      return expected_angles.size();
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t in_coord_y;
  coord_t in_coord_x;
  logic   out_valid;
  angle_t out_angle;

  angle_scoreboard sb = new;
  int quiet_cycles;

  atan2_rational_approx u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_coord_y(in_coord_y),
    .in_coord_x(in_coord_x),
    .out_valid (out_valid),
    .out_angle (out_angle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: sample both channels at the edge that accepts them. All inputs
  // are driven with nonblocking assignments, so values read here are the
  // ones the block sees at this edge. Also runs the hang watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_pair(in_coord_y, in_coord_x);
      if (out_valid) sb.check_angle(out_angle);
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                 quiet_cycles, sb.pending());
        $display("atan2_rational_approx regression: fail");
        $finish;
      end
    end
  end

  // Present one pair and hold it until the block takes it. Returns in the
  // time step of the accepting edge, with start still high.
  task automatic send_pair(input coord_t y, input coord_t x);
    start      <= 1'b1;
    in_coord_y <= y;
    in_coord_x <= x;
    do @(posedge clk); while (busy);
  endtask

  // Random sender gap: each cycle idles with probability idle_pct percent.
  task automatic sender_gap(input int idle_pct);
    int n;
    n = 0;
    while (n < MAX_GAP && $urandom_range(99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic coord_t near_extreme();
    case ($urandom_range(6))
      0: return C_MIN;
      1: return coord_t'(C_MIN + 1);
      2: return C_MAX;
      3: return coord_t'(C_MAX - 1);
      4: return 0;
      5: return 1;
      default: return -1;
    endcase
  endfunction

  // Random pair, weighted toward the axes, the diagonals and the corners
  // where the ratio hits its limits; the rest is uniform over the full range.
  task automatic send_random_pair();
    coord_t y, x;
    y = coord_t'($urandom);
    x = coord_t'($urandom);
    case ($urandom_range(9))
      4: x = 0;
      5: y = 0;
      6: begin
        // |y| == |x|: ratio exactly zero
        y = (x == C_MIN) ? C_MIN : (($urandom_range(1) != 0) ? x : -x);
      end
      7: begin
        y = coord_t'($signed($urandom_range(16)) - 8);
        x = coord_t'($signed($urandom_range(16)) - 8);
      end
      8: begin
        y = near_extreme();
        x = near_extreme();
      end
      9: begin
        // one small component against a large one
        if ($urandom_range(1) != 0) y = coord_t'($signed($urandom_range(6)) - 3);
        else x = coord_t'($signed($urandom_range(6)) - 3);
      end
      default: ;
    endcase
    send_pair(y, x);
  endtask

  initial begin
    int idle_pct[4];
    idle_pct = '{0, 77, 21, 0};
    quiet_cycles = 0;
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_coord_y <= '0;
    in_coord_x <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: origin, both axes, all four corners, unit steps, diagonals.
    send_pair(0, 0);
    send_pair(1, 0);
    send_pair(-1, 0);
    send_pair(C_MAX, 0);
    send_pair(C_MIN, 0);
    send_pair(0, 1);
    send_pair(0, C_MAX);
    send_pair(0, -1);
    send_pair(0, C_MIN);
    send_pair(C_MAX, C_MAX);
    send_pair(C_MIN, C_MIN);
    send_pair(C_MIN, C_MAX);
    send_pair(C_MAX, C_MIN);
    send_pair(1, 1);
    send_pair(-1, 1);
    send_pair(1, -1);
    send_pair(-1, -1);
    send_pair(1, C_MAX);
    send_pair(C_MAX, 1);
    send_pair(C_MIN, 1);
    send_pair(1, C_MIN);
    send_pair(-1, C_MIN);
    send_pair(C_MIN, -1);
    send_pair(C_MAX, -1);

    // Random phases: back to back, heavy sender idling, light idling, back to back.
    foreach (idle_pct[p]) begin
      repeat (PHASE_ITEMS) begin
        sender_gap(idle_pct[p]);
        send_random_pair();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d coordinate pairs: %0d with x == 0, %0d with x > 0, %0d with x < 0",
             sb.pairs_seen, sb.axis_pairs, sb.right_pairs, sb.left_pairs);
    $display("%0d angles compared, %0d mismatches", sb.angles_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("atan2_rational_approx regression: pass");
    end else begin
      $display("atan2_rational_approx regression: fail");
    end
    $finish;
  end

endmodule
